### rtl/mau_pkg.sv
// shared types and constants for the modular arithmetic unit
// no dependencies; used by mau_ctrl, mau_dp and the top level
package mau_pkg;

  localparam int RES_W            = 31;
  localparam int COEF_W           = RES_W + 2;
  localparam int OPERAND_BITS_DEF = 32;

  localparam logic [RES_W-1:0] MODULUS_RESET = 31'd1000000007;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_POW = 3'd4,
    CMD_INV = 3'd5
  } cmd_t;

  typedef enum logic [4:0] {
    DP_NOP       = 5'd0,
    DP_LOAD      = 5'd1,
    DP_REDUCE    = 5'd2,
    DP_ADD       = 5'd3,
    DP_SUB       = 5'd4,
    DP_ZERO      = 5'd5,
    DP_POW_INIT  = 5'd6,
    DP_MUL_LD_AB = 5'd7,
    DP_MUL_LD_AR = 5'd8,
    DP_MUL_LD_RX = 5'd9,
    DP_MUL_LD_XX = 5'd10,
    DP_MUL_STEP  = 5'd11,
    DP_WB_RES    = 5'd12,
    DP_WB_BASE   = 5'd13,
    DP_EUC_LD_A  = 5'd14,
    DP_EUC_LD_B  = 5'd15,
    DP_DIV_INIT  = 5'd16,
    DP_DIV_STEP  = 5'd17,
    DP_EUC_UPD   = 5'd18,
    DP_EUC_FIN   = 5'd19
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic m_small;
    logic exp_lsb;
    logic exp_hi_zero;
    logic r1_zero;
  } dp_status_t;

endpackage

### rtl/mau_dp.sv
// datapath: modulus register, operand reduction, bit-serial modular multiplier,
// extended euclid with restoring divider, output register
// depends on mau_pkg; driven by mau_ctrl
module mau_dp #(
  parameter int OPERAND_BITS = mau_pkg::OPERAND_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [mau_pkg::RES_W-1:0]   cfg_wdata,
  input  logic [OPERAND_BITS-1:0]     operand_a,
  input  logic [OPERAND_BITS-1:0]     operand_b,
  input  mau_pkg::dp_cmd_t            ctl,
  output mau_pkg::dp_status_t         sts,
  output logic [mau_pkg::RES_W-1:0]   residue
);

  localparam int W  = mau_pkg::RES_W;
  localparam int CW = mau_pkg::COEF_W;

  logic [W-1:0]            modulus;
  logic [OPERAND_BITS-1:0] opa, opb;
  logic [W-1:0]            ea, eb, res;
  logic [W-1:0]            mx, my, mp;
  logic [W-1:0]            r0, r1, dsh, drem;
  logic signed [CW-1:0]    c0, c1, dt;

  logic [W:0]              red_a_sh, red_b_sh, red_a, red_b;
  logic [W:0]              add_sum, add_res;
  logic [W-1:0]            sub_res;
  logic [W+1:0]            mul_t, mul_m1, mul_m2, mul_res;
  logic [W:0]              div_rr, div_rem;
  logic                    div_ge;
  logic signed [CW-1:0]    dt_next, m_sig, c_norm;

  always_comb begin
    red_a_sh = {ea, opa[OPERAND_BITS-1]};
    red_b_sh = {eb, opb[OPERAND_BITS-1]};
    red_a    = (red_a_sh >= {1'b0, modulus}) ? red_a_sh - {1'b0, modulus} : red_a_sh;
    red_b    = (red_b_sh >= {1'b0, modulus}) ? red_b_sh - {1'b0, modulus} : red_b_sh;

    add_sum  = {1'b0, ea} + {1'b0, eb};
    add_res  = (add_sum >= {1'b0, modulus}) ? add_sum - {1'b0, modulus} : add_sum;
    sub_res  = (ea >= eb) ? ea - eb : ea - eb + modulus;

    // shift-and-add, at most two moduli to remove per step
    mul_t    = {1'b0, mp, 1'b0} + {2'b00, (my[W-1] ? mx : {W{1'b0}})};
    mul_m1   = {2'b00, modulus};
    mul_m2   = {1'b0, modulus, 1'b0};
    if (mul_t >= mul_m2) begin
      mul_res = mul_t - mul_m2;
    end else if (mul_t >= mul_m1) begin
      mul_res = mul_t - mul_m1;
    end else begin
      mul_res = mul_t;
    end

    // one quotient bit per step, quotient times c1 accumulated alongside
    div_rr   = {drem, dsh[W-1]};
    div_ge   = (div_rr >= {1'b0, r1});
    div_rem  = div_ge ? div_rr - {1'b0, r1} : div_rr;
    dt_next  = (dt <<< 1) + (div_ge ? c1 : {CW{1'b0}});

    m_sig    = $signed({2'b00, modulus});
    if (c0[CW-1]) begin
      c_norm = c0 + m_sig;
    end else if (c0 >= m_sig) begin
      c_norm = c0 - m_sig;
    end else begin
      c_norm = c0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= mau_pkg::MODULUS_RESET;
    end else if (cfg_we) begin
      modulus <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      mau_pkg::DP_NOP: begin
      end
      mau_pkg::DP_LOAD: begin
        opa <= operand_a;
        opb <= operand_b;
        ea  <= '0;
        eb  <= '0;
      end
      mau_pkg::DP_REDUCE: begin
        ea  <= red_a[W-1:0];
        eb  <= red_b[W-1:0];
        opa <= {opa[OPERAND_BITS-2:0], opa[OPERAND_BITS-1]};
        opb <= {opb[OPERAND_BITS-2:0], opb[OPERAND_BITS-1]};
      end
      mau_pkg::DP_ADD:      res <= add_res[W-1:0];
      mau_pkg::DP_SUB:      res <= sub_res;
      mau_pkg::DP_ZERO:     res <= '0;
      mau_pkg::DP_POW_INIT: res <= {{(W-1){1'b0}}, 1'b1};
      mau_pkg::DP_MUL_LD_AB: begin
        mx <= ea;
        my <= eb;
        mp <= '0;
      end
      mau_pkg::DP_MUL_LD_AR: begin
        mx <= ea;
        my <= res;
        mp <= '0;
      end
      mau_pkg::DP_MUL_LD_RX: begin
        mx <= res;
        my <= ea;
        mp <= '0;
      end
      mau_pkg::DP_MUL_LD_XX: begin
        mx <= ea;
        my <= ea;
        mp <= '0;
      end
      mau_pkg::DP_MUL_STEP: begin
        mp <= mul_res[W-1:0];
        my <= {my[W-2:0], 1'b0};
      end
      mau_pkg::DP_WB_RES: res <= mp;
      mau_pkg::DP_WB_BASE: begin
        ea  <= mp;
        opb <= opb >> 1;
      end
      mau_pkg::DP_EUC_LD_A: begin
        r0 <= modulus;
        r1 <= ea;
        c0 <= '0;
        c1 <= {{(CW-1){1'b0}}, 1'b1};
      end
      mau_pkg::DP_EUC_LD_B: begin
        r0 <= modulus;
        r1 <= eb;
        c0 <= '0;
        c1 <= {{(CW-1){1'b0}}, 1'b1};
      end
      mau_pkg::DP_DIV_INIT: begin
        dsh  <= r0;
        drem <= '0;
        dt   <= '0;
      end
      mau_pkg::DP_DIV_STEP: begin
        drem <= div_rem[W-1:0];
        dsh  <= {dsh[W-2:0], 1'b0};
        dt   <= dt_next;
      end
      mau_pkg::DP_EUC_UPD: begin
        r0 <= r1;
        r1 <= drem;
        c0 <= c1;
        c1 <= c0 - dt;
      end
      mau_pkg::DP_EUC_FIN: res <= c_norm[W-1:0];
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      residue <= res;
    end
  end

  assign sts.m_small     = (modulus[W-1:1] == '0);
  assign sts.exp_lsb     = opb[0];
  assign sts.exp_hi_zero = (opb[OPERAND_BITS-1:1] == '0);
  assign sts.r1_zero     = (r1 == '0);

endmodule

### rtl/mau_ctrl.sv
// controller: sequences reduction, add/sub, multiply, euclid inverse and
// square-and-multiply on the datapath; owns the channel handshake
// depends on mau_pkg; drives mau_dp
module mau_ctrl #(
  parameter int OPERAND_BITS = mau_pkg::OPERAND_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          cmd,
  output logic                out_valid,
  input  logic                out_stall,
  input  mau_pkg::dp_status_t sts,
  output mau_pkg::dp_cmd_t    ctl
);

  localparam int CntW = $clog2((OPERAND_BITS > mau_pkg::RES_W) ? OPERAND_BITS
                                                                : mau_pkg::RES_W);

  typedef enum logic [11:0] {
    S_IDLE      = 12'b0000_0000_0001,
    S_REDUCE    = 12'b0000_0000_0010,
    S_DISPATCH  = 12'b0000_0000_0100,
    S_MUL_SETUP = 12'b0000_0000_1000,
    S_MUL       = 12'b0000_0001_0000,
    S_MUL_WB    = 12'b0000_0010_0000,
    S_EUC_CHECK = 12'b0000_0100_0000,
    S_DIV       = 12'b0000_1000_0000,
    S_EUC_UPD   = 12'b0001_0000_0000,
    S_EUC_FIN   = 12'b0010_0000_0000,
    S_POW_CHECK = 12'b0100_0000_0000,
    S_EMIT      = 12'b1000_0000_0000
  } state_t;

  state_t            state, state_next;
  mau_pkg::cmd_t     command, command_next;
  logic [CntW-1:0]   cnt, cnt_next;
  logic              pow_sq, pow_sq_next;
  logic              bit_done, bit_done_next;
  logic              out_valid_next;
  logic              out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next     = state;
    command_next   = command;
    cnt_next       = cnt;
    pow_sq_next    = pow_sq;
    bit_done_next  = bit_done;
    out_valid_next = out_valid && out_stall;
    ctl.op         = mau_pkg::DP_NOP;
    ctl.load_out   = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.op       = mau_pkg::DP_LOAD;
          command_next = mau_pkg::cmd_t'(cmd);
          cnt_next     = CntW'(OPERAND_BITS - 1);
          state_next   = S_REDUCE;
        end
      end
      S_REDUCE: begin
        ctl.op   = mau_pkg::DP_REDUCE;
        cnt_next = cnt - 1'b1;
        if (cnt == '0) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.m_small) begin
          ctl.op     = mau_pkg::DP_ZERO;
          state_next = S_EMIT;
        end else begin
          unique case (command)
            mau_pkg::CMD_ADD: begin
              ctl.op     = mau_pkg::DP_ADD;
              state_next = S_EMIT;
            end
            mau_pkg::CMD_SUB: begin
              ctl.op     = mau_pkg::DP_SUB;
              state_next = S_EMIT;
            end
            mau_pkg::CMD_MUL: state_next = S_MUL_SETUP;
            mau_pkg::CMD_DIV: begin
              ctl.op     = mau_pkg::DP_EUC_LD_B;
              state_next = S_EUC_CHECK;
            end
            mau_pkg::CMD_POW: begin
              ctl.op        = mau_pkg::DP_POW_INIT;
              bit_done_next = 1'b0;
              state_next    = S_POW_CHECK;
            end
            mau_pkg::CMD_INV: begin
              ctl.op     = mau_pkg::DP_EUC_LD_A;
              state_next = S_EUC_CHECK;
            end
            default: begin
              ctl.op     = mau_pkg::DP_ZERO;
              state_next = S_EMIT;
            end
          endcase
        end
      end
      S_MUL_SETUP: begin
        cnt_next   = CntW'(mau_pkg::RES_W - 1);
        state_next = S_MUL;
        if (command == mau_pkg::CMD_DIV) begin
          ctl.op = mau_pkg::DP_MUL_LD_AR;
        end else if (command == mau_pkg::CMD_POW) begin
          ctl.op = pow_sq ? mau_pkg::DP_MUL_LD_XX : mau_pkg::DP_MUL_LD_RX;
        end else begin
          ctl.op = mau_pkg::DP_MUL_LD_AB;
        end
      end
      S_MUL: begin
        ctl.op   = mau_pkg::DP_MUL_STEP;
        cnt_next = cnt - 1'b1;
        if (cnt == '0) begin
          state_next = S_MUL_WB;
        end
      end
      S_MUL_WB: begin
        if (command == mau_pkg::CMD_POW) begin
          state_next = S_POW_CHECK;
          if (pow_sq) begin
            ctl.op        = mau_pkg::DP_WB_BASE;
            bit_done_next = 1'b0;
          end else begin
            ctl.op        = mau_pkg::DP_WB_RES;
            bit_done_next = 1'b1;
          end
        end else begin
          ctl.op     = mau_pkg::DP_WB_RES;
          state_next = S_EMIT;
        end
      end
      S_EUC_CHECK: begin
        if (sts.r1_zero) begin
          state_next = S_EUC_FIN;
        end else begin
          ctl.op     = mau_pkg::DP_DIV_INIT;
          cnt_next   = CntW'(mau_pkg::RES_W - 1);
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        ctl.op   = mau_pkg::DP_DIV_STEP;
        cnt_next = cnt - 1'b1;
        if (cnt == '0) begin
          state_next = S_EUC_UPD;
        end
      end
      S_EUC_UPD: begin
        ctl.op     = mau_pkg::DP_EUC_UPD;
        state_next = S_EUC_CHECK;
      end
      S_EUC_FIN: begin
        ctl.op     = mau_pkg::DP_EUC_FIN;
        state_next = (command == mau_pkg::CMD_DIV) ? S_MUL_SETUP : S_EMIT;
      end
      S_POW_CHECK: begin
        if (sts.exp_hi_zero && !sts.exp_lsb) begin
          state_next = S_EMIT;
        end else if (sts.exp_lsb && !bit_done) begin
          pow_sq_next = 1'b0;
          state_next  = S_MUL_SETUP;
        end else if (sts.exp_hi_zero) begin
          // last exponent bit done, final squaring not needed
          state_next = S_EMIT;
        end else begin
          pow_sq_next = 1'b1;
          state_next  = S_MUL_SETUP;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ctl.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      command   <= mau_pkg::CMD_ADD;
      cnt       <= '0;
      pow_sq    <= 1'b0;
      bit_done  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      command   <= command_next;
      cnt       <= cnt_next;
      pow_sq    <= pow_sq_next;
      bit_done  <= bit_done_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### rtl/modular_arithmetic_unit.sv
// top level of the modular arithmetic unit: controller plus datapath
// depends on mau_pkg, mau_ctrl, mau_dp
//
//   channel  signals                              direction
//   in       in_valid in_stall cmd operand_a/b    input item
//   out      out_valid out_stall residue          one residue per item
//   cfg      cfg_we cfg_wdata                     modulus write
//
// one item at a time; operands are reduced one bit a cycle
// each modular multiply takes 31 shift-and-add steps; power squares once per
// exponent bit below the top set bit, multiplies once per set bit
// the next item is taken while a finished residue waits in the output register
// synchronous reset returns the controller to idle and the modulus to 1000000007
module modular_arithmetic_unit #(
  parameter int OPERAND_BITS = mau_pkg::OPERAND_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [mau_pkg::RES_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                cmd,
  input  logic [OPERAND_BITS-1:0]   operand_a,
  input  logic [OPERAND_BITS-1:0]   operand_b,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [mau_pkg::RES_W-1:0] residue
);

  mau_pkg::dp_cmd_t    ctl;
  mau_pkg::dp_status_t sts;

  mau_ctrl #(
    .OPERAND_BITS (OPERAND_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  mau_dp #(
    .OPERAND_BITS (OPERAND_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .ctl       (ctl),
    .sts       (sts),
    .residue   (residue)
  );

endmodule

### rtl/mau_checker.sv
// port-level checks for modular_arithmetic_unit, attached by bind
// depends on mau_pkg for the residue width
module mau_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [mau_pkg::RES_W-1:0] residue
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(residue))
    else $error("residue changed or dropped while stalled");

  // one item at a time: busy right after a transfer in
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in flight");

  // returning to idle always leaves a result behind
  a_idle_has_result: assert property (@(posedge clk) disable iff (rst)
    $fell(in_stall) |-> out_valid)
    else $error("unit went idle without presenting a result");

  // a new result only appears at the end of an item
  a_result_from_item: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in flight");

endmodule

bind modular_arithmetic_unit mau_checker u_mau_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .residue   (residue)
);

### test/residue_checker.sv
`timescale 1ns / 1ps
// residue checker for the modular arithmetic unit: tracks the modulus register,
// predicts the residue of every input transfer and compares output transfers in order
// depends on mau_pkg
module residue_checker #(
  parameter int OP_W = mau_pkg::OPERAND_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [mau_pkg::RES_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [2:0]                cmd,
  input  logic [OP_W-1:0]           operand_a,
  input  logic [OP_W-1:0]           operand_b,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [mau_pkg::RES_W-1:0] residue,
  output int                        errors,
  output int                        outstanding
);

  logic [mau_pkg::RES_W-1:0] modulus_now;
  logic [mau_pkg::RES_W-1:0] pending_residues [$];
  logic [mau_pkg::RES_W-1:0] predicted;
  logic [mau_pkg::RES_W-1:0] want;

  function automatic longint unsigned mulmod(longint unsigned x, longint unsigned y,
                                             longint unsigned m);
    return (x * y) % m;
  endfunction

  // extended euclid; the coefficient left over is the inverse for a prime modulus
  function automatic longint unsigned inv_mod(longint unsigned val, longint unsigned m);
    longint r0, r1, c0, c1, q, tr, tc, sm;
    sm = longint'(m);
    r0 = longint'(val % m);
    r1 = sm;
    c0 = 1;
    c1 = 0;
    while (r1 != 0) begin
      q  = r0 / r1;
      tr = r0 - q * r1;
      tc = c0 - q * c1;
      r0 = r1;
      r1 = tr;
      c0 = c1;
      c1 = tc;
    end
    return longint'(((c0 % sm) + sm) % sm);
  endfunction

  function automatic longint unsigned pow_mod(longint unsigned base, logic [OP_W-1:0] ex,
                                              longint unsigned m);
    longint unsigned acc, sq;
    logic [OP_W-1:0] e;
    acc = 1 % m;
    sq  = base % m;
    e   = ex;
    while (e != 0) begin
      if (e[0]) acc = mulmod(acc, sq, m);
      sq = mulmod(sq, sq, m);
      e  = e >> 1;
    end
    return acc;
  endfunction

  function automatic logic [mau_pkg::RES_W-1:0] predict_residue(
    logic [2:0] c, logic [OP_W-1:0] a, logic [OP_W-1:0] b, logic [mau_pkg::RES_W-1:0] m);
    longint unsigned mm, ra, rb, r;
    mm = 64'(m);
    r  = 0;
    if (mm >= 2) begin
      ra = a % mm;
      rb = b % mm;
      case (c)
        mau_pkg::CMD_ADD: r = (ra + rb) % mm;
        mau_pkg::CMD_SUB: r = (ra + mm - rb) % mm;
        mau_pkg::CMD_MUL: r = mulmod(ra, rb, mm);
        mau_pkg::CMD_DIV: r = mulmod(ra, inv_mod(rb, mm), mm);
        mau_pkg::CMD_POW: r = pow_mod(ra, b, mm);
        mau_pkg::CMD_INV: r = inv_mod(ra, mm);
        default: r = 0;
      endcase
    end
    return r[mau_pkg::RES_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      errors      = 0;
      modulus_now = mau_pkg::MODULUS_RESET;
      pending_residues.delete();
    end else begin
      if (cfg_we) modulus_now = cfg_wdata;
      if (in_valid && !in_stall) begin
        predicted        = predict_residue(cmd, operand_a, operand_b, modulus_now);
        pending_residues = {pending_residues, predicted};
      end
      if (out_valid && !out_stall) begin
        if (pending_residues.size() == 0) begin
          errors = errors + 1;
          $display("%0t: unexpected residue transfer: expected none, actual %0d",
                   $time, residue);
        end else begin
          want = pending_residues.pop_front();
          if (residue !== want) begin
            errors = errors + 1;
            $display("%0t: residue mismatch: expected %0d, actual %0d", $time, want, residue);
          end
        end
      end
    end
    outstanding = pending_residues.size();
  end

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// top of the modular arithmetic unit testbench: clock, reset, stimulus, stalls, verdict
// depends on mau_pkg, modular_arithmetic_unit and residue_checker
module tb;

  localparam int OP_W = mau_pkg::OPERAND_BITS_DEF;
  localparam int RW = mau_pkg::RES_W;
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_ITEMS = 85;
  localparam int LONG_HOLD = 6000;
  localparam int DRAIN_CYCLES = 3000;
  localparam longint CYCLE_LIMIT = 10_000_000;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [RW-1:0]    cfg_wdata;
  logic             in_valid;
  logic             in_stall;
  logic [2:0]       cmd;
  logic [OP_W-1:0]  operand_a;
  logic [OP_W-1:0]  operand_b;
  logic             out_valid;
  logic             out_stall;
  logic [RW-1:0]    residue;
  int               errors;
  int               outstanding;

  logic [RW-1:0]    phase_moduli [NUM_PHASES];
  longint           cycles;
  int               rx_count;
  int               hold;
  bit               quiet_in;
  bit               quiet_out;
  int               p;
  int               i;

  modular_arithmetic_unit #(.OPERAND_BITS(OP_W)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .residue   (residue)
  );

  residue_checker #(.OP_W(OP_W)) chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .operand_a   (operand_a),
    .operand_b   (operand_b),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .residue     (residue),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: errors");
    $finish;
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_op(input logic [2:0] c, input logic [OP_W-1:0] a,
                         input logic [OP_W-1:0] b);
    int gap;
    gap = quiet_in ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic set_modulus(input logic [RW-1:0] m);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [2:0] pick_cmd();
    int r;
    r = $urandom_range(0, 13);
    if (r == 12) return CMD_RSVD6;
    if (r == 13) return CMD_RSVD7;
    return 3'(r % 6);
  endfunction

  // mostly edge values around the modulus, plus small values up to 40 and full random words
  function automatic logic [OP_W-1:0] pick_operand(input logic [RW-1:0] m);
    logic [OP_W-1:0] mw;
    mw = OP_W'(m);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return mw - 1;
      3: return mw;
      4: return mw + 1;
      5: return mw * $urandom_range(2, 3);
      6, 7: return OP_W'($urandom_range(0, 40));
      default: return OP_W'($urandom());
    endcase
  endfunction

  // output side: random stall per transfer, two long hold-offs
  initial begin
    out_stall = 1'b0;
    rx_count  = 0;
    quiet_out = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (rx_count % 40 == 0) quiet_out = ($urandom_range(0, 3) == 0);
      hold = quiet_out ? 0 : $urandom_range(0, 10);
      if (rx_count == 150 || rx_count == 500) hold = LONG_HOLD;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      rx_count++;
      @(negedge clk);
    end
  end

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    cmd       = '0;
    operand_a = '0;
    operand_b = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    quiet_in  = 1'b0;
    phase_moduli = '{mau_pkg::MODULUS_RESET, 31'h7fffffff, 31'd2, 31'd3, 31'd65521,
                     31'd1000000000, 31'd0, 31'd1, 31'd0, 31'd97};
    phase_moduli[6] = RW'($urandom_range(2, 32'h7fffffff));
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_op(mau_pkg::CMD_ADD, '1, '1);
    send_op(mau_pkg::CMD_SUB, '0, '1);
    send_op(mau_pkg::CMD_MUL, '1, 32'hfffffffe);
    send_op(mau_pkg::CMD_DIV, 32'd12345, '0);
    send_op(mau_pkg::CMD_DIV, 32'd1, OP_W'(mau_pkg::MODULUS_RESET));
    send_op(mau_pkg::CMD_DIV, 32'hdeadbeef, 32'd7);
    send_op(mau_pkg::CMD_POW, '0, '0);
    send_op(mau_pkg::CMD_POW, 32'd2, '1);
    send_op(mau_pkg::CMD_INV, '0, '0);
    send_op(mau_pkg::CMD_INV, OP_W'(mau_pkg::MODULUS_RESET), '0);
    send_op(mau_pkg::CMD_INV, '1, '1);
    send_op(CMD_RSVD6, 32'd5, 32'd6);
    send_op(CMD_RSVD7, '1, '1);
    set_modulus(31'h7fffffff);
    send_op(mau_pkg::CMD_POW, '1, '1);
    send_op(mau_pkg::CMD_INV, 32'h7ffffffe, '0);
    send_op(mau_pkg::CMD_MUL, 32'h7ffffffe, 32'h7ffffffe);
    // composite modulus
    set_modulus(31'd1000000000);
    send_op(mau_pkg::CMD_INV, 32'd3, '0);
    send_op(mau_pkg::CMD_INV, 32'd2, '0);
    send_op(mau_pkg::CMD_DIV, 32'd7, 32'd6);
    set_modulus(31'd2);
    send_op(mau_pkg::CMD_SUB, '0, 32'd1);
    send_op(mau_pkg::CMD_POW, 32'd3, '0);
    set_modulus(31'd1);
    send_op(mau_pkg::CMD_POW, 32'd5, '0);
    set_modulus(31'd0);
    send_op(mau_pkg::CMD_ADD, 32'd1, 32'd1);
    send_op(mau_pkg::CMD_INV, 32'd3, '0);

    for (p = 0; p < NUM_PHASES; p++) begin
      set_modulus(phase_moduli[p]);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 0) quiet_in = ($urandom_range(0, 3) == 0);
        if (i == 42) settle();
        send_op(pick_cmd(), pick_operand(phase_moduli[p]), pick_operand(phase_moduli[p]));
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && outstanding == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
